// ===== design/signed_decimal_field_formatter_defines.svh =====
// Shared assertion macros for the formatter checker.
`ifndef SIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH
`define SIGNED_DECIMAL_FIELD_FORMATTER_DEFINES_SVH

// Same-cycle implication, sampled on the rising clock edge and quiet in reset.
`define SDFF_ASSERT_NOW(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("formatter assertion failed");

// Next-cycle implication.
`define SDFF_ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("formatter assertion failed");

`endif

// ===== design/sdff_pkg.sv =====
package sdff_pkg;

    // Largest field the formatter produces, in characters.
    localparam int MAX_FIELD = 64;
    // Width of a character count that can hold MAX_FIELD itself.
    localparam int CNT_W = $clog2(MAX_FIELD + 1);
    // Most decimal digits of a 32-bit magnitude.
    localparam int DIG_N = 10;
    localparam int NDIG_W = $clog2(DIG_N + 1);
    localparam int PREC_W = 6;
    localparam logic [PREC_W-1:0] PREC_MAX = PREC_W'(MAX_FIELD - 1);

    // Reciprocal of ten for a divide by multiply: q = (x * RECIP10) >> 35.
    localparam logic [31:0] RECIP10 = 32'hCCCC_CCCD;
    localparam int RECIP10_SHIFT = 35;

    localparam logic [7:0] ASCII_ZERO  = 8'h30;
    localparam logic [7:0] ASCII_MINUS = 8'h2D;
    localparam logic [7:0] ASCII_PLUS  = 8'h2B;
    localparam logic [7:0] ASCII_SPACE = 8'h20;

    typedef struct packed {
        logic load;
        logic conv_step;
        logic plan;
        logic emit;
    } t_cmd;

    typedef struct packed {
        logic conv_done;
        logic plan_empty;
        logic out_free;
        logic emit_last;
    } t_status;

endpackage

// ===== design/sdff_datapath.sv =====
module sdff_datapath (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  sdff_pkg::t_cmd            i_cmd,
    output sdff_pkg::t_status         o_status,
    input  logic signed [31:0]        i_value,
    input  logic [6:0]                i_field_width,
    input  logic [5:0]                i_precision_digits,
    input  logic                      i_has_precision,
    input  logic                      i_left_align,
    input  logic                      i_zero_pad,
    input  logic                      i_force_plus,
    input  logic                      i_space_sign,
    input  logic                      i_out_ready,
    output logic                      o_out_valid,
    output logic [7:0]                o_character,
    output logic                      o_last_char
);

    localparam int CW = sdff_pkg::CNT_W;
    localparam int NW = sdff_pkg::NDIG_W;
    localparam int DBITS = 4 * sdff_pkg::DIG_N;

    // Item registers
    logic [31:0]                    r_mag;
    logic [NW-1:0]                  r_ndig;
    logic                           r_nodig;
    logic [DBITS-1:0]               r_digits;
    logic [CW-1:0]                  r_width;
    logic [sdff_pkg::PREC_W-1:0]    r_prec;
    logic                           r_left;
    logic                           r_zp;
    logic [7:0]                     r_signch;
    logic                           r_has_sign;

    // Emission counters
    logic [CW-1:0]                  r_lead;
    logic [CW-1:0]                  r_zrun;
    logic [CW-1:0]                  r_trail;
    logic [NW-1:0]                  r_dleft;
    logic [CW-1:0]                  r_total;
    logic                           r_sign_pend;

    // Output register
    logic                           r_ovalid;
    logic [7:0]                     r_ochar;
    logic                           r_olast;

    // Load-time values
    logic [31:0]                    ld_mag;
    logic [CW-1:0]                  ld_width;
    logic [sdff_pkg::PREC_W-1:0]    ld_prec;
    logic [7:0]                     ld_signch;
    logic                           ld_has_sign;

    // Divide-by-ten step
    logic [63:0]                    prod;
    logic [31:0]                    quot;
    logic [31:0]                    rem;

    // Field plan
    logic [CW-1:0]                  ndig_c;
    logic [CW-1:0]                  prec_c;
    logic [CW-1:0]                  zeros;
    logic [CW-1:0]                  body;
    logic [CW-1:0]                  pad;
    logic [CW-1:0]                  total;

    logic [7:0]                     emit_char;

    always_comb begin
        ld_mag = i_value[31] ? (~i_value + 32'd1) : i_value;
        ld_width = (i_field_width > CW'(sdff_pkg::MAX_FIELD))
            ? CW'(sdff_pkg::MAX_FIELD) : CW'(i_field_width);
        if (!i_has_precision) begin
            ld_prec = '0;
        end else if (i_precision_digits > sdff_pkg::PREC_MAX) begin
            ld_prec = sdff_pkg::PREC_MAX;
        end else begin
            ld_prec = i_precision_digits;
        end
        ld_has_sign = 1'b1;
        if (i_value[31]) begin
            ld_signch = sdff_pkg::ASCII_MINUS;
        end else if (i_force_plus) begin
            ld_signch = sdff_pkg::ASCII_PLUS;
        end else if (i_space_sign) begin
            ld_signch = sdff_pkg::ASCII_SPACE;
        end else begin
            ld_signch = sdff_pkg::ASCII_SPACE;
            ld_has_sign = 1'b0;
        end
    end

    always_comb begin
        prod = {32'd0, r_mag} * {32'd0, sdff_pkg::RECIP10};
        quot = 32'(prod[63:sdff_pkg::RECIP10_SHIFT]);
        rem = r_mag - ((quot << 3) + (quot << 1));
    end

    always_comb begin
        ndig_c = CW'(r_ndig);
        prec_c = CW'(r_prec);
        zeros = (prec_c > ndig_c) ? (prec_c - ndig_c) : '0;
        body = CW'(r_has_sign) + zeros + ndig_c;
        pad = (r_width > body) ? (r_width - body) : '0;
        total = body + pad;
    end

    // Segments go out in field order; the zero run covers both zero padding
    // and precision zeros since they are adjacent.
    always_comb begin
        if (r_lead != '0) begin
            emit_char = sdff_pkg::ASCII_SPACE;
        end else if (r_sign_pend) begin
            emit_char = r_signch;
        end else if (r_zrun != '0) begin
            emit_char = sdff_pkg::ASCII_ZERO;
        end else if (r_dleft != '0) begin
            emit_char = sdff_pkg::ASCII_ZERO + 8'(r_digits[DBITS-1 -: 4]);
        end else begin
            emit_char = sdff_pkg::ASCII_SPACE;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.load) begin
            r_mag <= ld_mag;
            r_ndig <= '0;
            r_nodig <= (ld_mag == 32'd0) && i_has_precision && (ld_prec == '0);
            r_width <= ld_width;
            r_prec <= ld_prec;
            r_left <= i_left_align;
            r_zp <= i_zero_pad && !i_left_align && !i_has_precision;
            r_signch <= ld_signch;
            r_has_sign <= ld_has_sign;
        end else if (i_cmd.conv_step) begin
            // Digits enter at the top, so the most significant ends up first.
            r_digits <= {rem[3:0], r_digits[DBITS-1:4]};
            r_mag <= quot;
            r_ndig <= r_ndig + NW'(1);
        end else if (i_cmd.emit && (r_lead == '0) && !r_sign_pend && (r_zrun == '0)
                     && (r_dleft != '0)) begin
            r_digits <= {r_digits[DBITS-5:0], 4'd0};
        end

        if (i_cmd.plan) begin
            r_lead <= (!r_left && !r_zp) ? pad : '0;
            r_zrun <= zeros + (r_zp ? pad : '0);
            r_trail <= r_left ? pad : '0;
            r_dleft <= r_ndig;
            r_total <= total;
            r_sign_pend <= r_has_sign;
        end else if (i_cmd.emit) begin
            r_total <= r_total - CW'(1);
            if (r_lead != '0) begin
                r_lead <= r_lead - CW'(1);
            end else if (r_sign_pend) begin
                r_sign_pend <= 1'b0;
            end else if (r_zrun != '0) begin
                r_zrun <= r_zrun - CW'(1);
            end else if (r_dleft != '0) begin
                r_dleft <= r_dleft - NW'(1);
            end else begin
                r_trail <= r_trail - CW'(1);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_ovalid <= 1'b0;
        end else if (i_cmd.emit) begin
            r_ovalid <= 1'b1;
        end else if (i_out_ready) begin
            r_ovalid <= 1'b0;
        end
        if (i_cmd.emit) begin
            r_ochar <= emit_char;
            r_olast <= (r_total == CW'(1));
        end
    end

    always_comb begin
        o_status.conv_done = r_nodig || ((r_ndig != '0) && (r_mag == 32'd0));
        o_status.plan_empty = (total == '0);
        o_status.out_free = !r_ovalid || i_out_ready;
        o_status.emit_last = (r_total == CW'(1));
    end

    assign o_out_valid = r_ovalid;
    assign o_character = r_ochar;
    assign o_last_char = r_olast;

endmodule

// ===== design/sdff_ctrl.sv =====
module sdff_ctrl (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  sdff_pkg::t_status   i_status,
    output sdff_pkg::t_cmd      o_cmd
);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_PLAN,
        S_EMIT
    } t_state;

    t_state r_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            unique case (r_state)
                S_IDLE: begin
                    if (i_valid) begin
                        r_state <= S_CONV;
                    end
                end
                S_CONV: begin
                    if (i_status.conv_done) begin
                        r_state <= S_PLAN;
                    end
                end
                S_PLAN: begin
                    // An empty field ends the request with no characters.
                    r_state <= i_status.plan_empty ? S_IDLE : S_EMIT;
                end
                S_EMIT: begin
                    if (i_status.out_free && i_status.emit_last) begin
                        r_state <= S_IDLE;
                    end
                end
                default: begin
                    r_state <= S_IDLE;
                end
            endcase
        end
    end

    always_comb begin
        o_cmd.load = (r_state == S_IDLE) && i_valid;
        o_cmd.conv_step = (r_state == S_CONV) && !i_status.conv_done;
        o_cmd.plan = (r_state == S_PLAN);
        o_cmd.emit = (r_state == S_EMIT) && i_status.out_free;
    end

    assign o_ready = (r_state == S_IDLE);

endmodule

// ===== design/signed_decimal_field_formatter.sv =====
// Channel   Direction  Handshake            Payload
// request   in         i_valid / o_ready    i_value .. i_space_sign
// char      out        o_valid / i_ready    o_character, o_last_char
//
// One request is accepted, then converted one decimal digit per step in the
// divide-by-ten loop (0 to 10 digits) until the controller sees the loop finish;
// the field is then sized, and the characters go out one per cycle while the
// output register is free. A multiply-by-reciprocal divider makes each digit.
// Reset is synchronous and active low; it clears the controller and o_valid.
// A stalled output only holds the emit phase; the next request is taken
// while the final character still waits in the output register.
module signed_decimal_field_formatter (
    input  logic                i_clk,
    input  logic                i_rst_n,
    input  logic                i_valid,
    output logic                o_ready,
    input  logic signed [31:0]  i_value,
    input  logic [6:0]          i_field_width,
    input  logic [5:0]          i_precision_digits,
    input  logic                i_has_precision,
    input  logic                i_left_align,
    input  logic                i_zero_pad,
    input  logic                i_force_plus,
    input  logic                i_space_sign,
    output logic                o_valid,
    input  logic                i_ready,
    output logic [7:0]          o_character,
    output logic                o_last_char
);

    sdff_pkg::t_cmd    cmd;
    sdff_pkg::t_status status;

    sdff_ctrl u_ctrl (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_valid  (i_valid),
        .o_ready  (o_ready),
        .i_status (status),
        .o_cmd    (cmd)
    );

    sdff_datapath u_dp (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_cmd              (cmd),
        .o_status           (status),
        .i_value            (i_value),
        .i_field_width      (i_field_width),
        .i_precision_digits (i_precision_digits),
        .i_has_precision    (i_has_precision),
        .i_left_align       (i_left_align),
        .i_zero_pad         (i_zero_pad),
        .i_force_plus       (i_force_plus),
        .i_space_sign       (i_space_sign),
        .i_out_ready        (i_ready),
        .o_out_valid        (o_valid),
        .o_character        (o_character),
        .o_last_char        (o_last_char)
    );

endmodule

// ===== design/sdff_checker.sv =====
`include "signed_decimal_field_formatter_defines.svh"

module sdff_checker (
    input logic         i_clk,
    input logic         i_rst_n,
    input logic         i_valid,
    input logic         o_ready,
    input logic         o_valid,
    input logic         i_ready,
    input logic [7:0]   o_character,
    input logic         o_last_char
);

    logic       out_stall;
    logic [8:0] out_word;
    logic       char_ok;

    assign out_stall = o_valid && !i_ready;
    assign out_word = {o_character, o_last_char};
    assign char_ok = (o_character == sdff_pkg::ASCII_SPACE)
        || (o_character == sdff_pkg::ASCII_PLUS)
        || (o_character == sdff_pkg::ASCII_MINUS)
        || ((o_character >= sdff_pkg::ASCII_ZERO)
            && (o_character <= sdff_pkg::ASCII_ZERO + 8'd9));

    // A character that is not taken stays put.
    `SDFF_ASSERT_NEXT(a_out_hold, i_clk, i_rst_n, out_stall, o_valid && $stable(out_word))

    // Only one request is in work at a time.
    `SDFF_ASSERT_NEXT(a_one_in_flight, i_clk, i_rst_n, i_valid && o_ready, !o_ready)

    // Every character is a space, a sign or a decimal digit.
    `SDFF_ASSERT_NOW(a_char_set, i_clk, i_rst_n, o_valid, char_ok)

endmodule

bind signed_decimal_field_formatter sdff_checker u_sdff_checker (.*);

// ===== verif/tb_signed_decimal_field_formatter.sv =====
`timescale 1ns / 100ps

module tb_signed_decimal_field_formatter;

    typedef struct {
        logic signed [31:0] value;
        logic [6:0]         field_width;
        logic [5:0]         prec_digits;
        logic               has_prec;
        logic               left_align;
        logic               zero_pad;
        logic               force_plus;
        logic               space_sign;
    } t_fmt_req;

    typedef struct {
        logic [7:0] ch;
        logic       last;
    } t_field_char;

    logic               i_clk = 1'b0;
    logic               i_rst_n = 1'b0;
    logic               i_valid = 1'b0;
    logic               o_ready;
    logic signed [31:0] i_value = '0;
    logic [6:0]         i_field_width = '0;
    logic [5:0]         i_precision_digits = '0;
    logic               i_has_precision = 1'b0;
    logic               i_left_align = 1'b0;
    logic               i_zero_pad = 1'b0;
    logic               i_force_plus = 1'b0;
    logic               i_space_sign = 1'b0;
    logic               o_valid;
    logic               i_ready = 1'b0;
    logic [7:0]         o_character;
    logic               o_last_char;

    t_fmt_req    pending_reqs[$];
    t_field_char expected_chars[$];
    t_fmt_req    offered_req;
    t_field_char want_char;
    int          reqs_queued = 0;
    int          reqs_accepted = 0;
    int          mismatch_count = 0;
    int          send_idle_pct = 0;
    int          recv_stall_pct = 0;
    logic        rx_hold = 1'b0;
    logic        start_backpressure = 1'b0;

    signed_decimal_field_formatter dut (
        .i_clk              (i_clk),
        .i_rst_n            (i_rst_n),
        .i_valid            (i_valid),
        .o_ready            (o_ready),
        .i_value            (i_value),
        .i_field_width      (i_field_width),
        .i_precision_digits (i_precision_digits),
        .i_has_precision    (i_has_precision),
        .i_left_align       (i_left_align),
        .i_zero_pad         (i_zero_pad),
        .i_force_plus       (i_force_plus),
        .i_space_sign       (i_space_sign),
        .o_valid            (o_valid),
        .i_ready            (i_ready),
        .o_character        (o_character),
        .o_last_char        (o_last_char)
    );

    always #2 i_clk = ~i_clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < 50) begin
            $display("ERROR @%0t: %s", $realtime, msg);
        end
        mismatch_count++;
    endtask

    // Builds the characters of one formatted field and queues them in order.
    function automatic void format_field(input t_fmt_req r);
        logic [31:0] mag;
        logic [7:0]  digits [10];
        logic [7:0]  sign_ch;
        logic [7:0]  line [$];
        int          width;
        int          prec;
        int          ndig;
        int          zeros;
        int          body;
        int          pad;
        bit          zp;
        mag = r.value[31] ? (~r.value + 32'd1) : r.value;
        width = (r.field_width > sdff_pkg::MAX_FIELD) ? sdff_pkg::MAX_FIELD
                                                      : int'(r.field_width);
        prec = r.has_prec ? int'(r.prec_digits) : 0;
        if (prec > sdff_pkg::MAX_FIELD - 1) begin
            prec = sdff_pkg::MAX_FIELD - 1;
        end
        zp = r.zero_pad && !r.left_align && !r.has_prec;
        ndig = 0;
        // A zero value with an explicit zero precision prints no digits at all.
        if (!(mag == 0 && r.has_prec && prec == 0)) begin
            do begin
                digits[ndig] = sdff_pkg::ASCII_ZERO + 8'(mag % 10);
                ndig++;
                mag = mag / 10;
            end while (mag != 0 && ndig < 10);
        end
        if (r.value[31]) begin
            sign_ch = sdff_pkg::ASCII_MINUS;
        end else if (r.force_plus) begin
            sign_ch = sdff_pkg::ASCII_PLUS;
        end else if (r.space_sign) begin
            sign_ch = sdff_pkg::ASCII_SPACE;
        end else begin
            sign_ch = 8'h00;
        end
        zeros = (prec > ndig) ? prec - ndig : 0;
        body = int'(sign_ch != 8'h00) + zeros + ndig;
        pad = (width > body) ? width - body : 0;
        if (!r.left_align && !zp) begin
            for (int i = 0; i < pad; i++) line.push_back(sdff_pkg::ASCII_SPACE);
        end
        if (sign_ch != 8'h00) begin
            line.push_back(sign_ch);
        end
        if (zp) begin
            for (int i = 0; i < pad; i++) line.push_back(sdff_pkg::ASCII_ZERO);
        end
        for (int i = 0; i < zeros; i++) line.push_back(sdff_pkg::ASCII_ZERO);
        for (int i = ndig - 1; i >= 0; i--) line.push_back(digits[i]);
        if (r.left_align) begin
            for (int i = 0; i < pad; i++) line.push_back(sdff_pkg::ASCII_SPACE);
        end
        while (line.size() > sdff_pkg::MAX_FIELD) line.pop_back();
        for (int i = 0; i < line.size(); i++) begin
            expected_chars.push_back(t_field_char'{ch: line[i],
                                                   last: (i == line.size() - 1)});
        end
    endfunction

    function automatic t_fmt_req make_req(input logic [31:0] value, input int width,
                                          input int prec, input bit hasp, input bit left,
                                          input bit zp, input bit plus, input bit space);
        t_fmt_req r;
        r.value = value;
        r.field_width = 7'(width);
        r.prec_digits = 6'(prec);
        r.has_prec = hasp;
        r.left_align = left;
        r.zero_pad = zp;
        r.force_plus = plus;
        r.space_sign = space;
        return r;
    endfunction

    function automatic t_fmt_req random_req();
        t_fmt_req r;
        int       pick;
        pick = int'($urandom_range(9));
        if (pick == 0) begin
            r.value = 32'd0;
        end else if (pick == 1) begin
            r.value = $urandom_range(1) ? 32'h8000_0000 : 32'h7FFF_FFFF;
        end else if (pick <= 3) begin
            r.value = $urandom_range(200) - 100;
        end else begin
            r.value = $urandom();
        end
        pick = int'($urandom_range(99));
        if (pick < 70) begin
            r.field_width = 7'($urandom_range(16));
        end else if (pick < 90) begin
            r.field_width = 7'($urandom_range(40));
        end else begin
            r.field_width = 7'($urandom_range(127));
        end
        r.prec_digits = ($urandom_range(99) < 75) ? 6'($urandom_range(12))
                                                  : 6'($urandom_range(63));
        r.has_prec = 1'($urandom_range(1));
        r.left_align = 1'($urandom_range(1));
        r.zero_pad = 1'($urandom_range(1));
        r.force_plus = 1'($urandom_range(1));
        r.space_sign = 1'($urandom_range(1));
        return r;
    endfunction

    // Request driver: predicts on acceptance, then offers the next pending request.
    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_valid <= 1'b0;
        end else begin
            if (i_valid && o_ready) begin
                format_field(offered_req);
                reqs_accepted++;
            end
            if (!i_valid || o_ready) begin
                if (pending_reqs.size() != 0 && $urandom_range(99) >= send_idle_pct) begin
                    offered_req = pending_reqs.pop_front();
                    i_value <= offered_req.value;
                    i_field_width <= offered_req.field_width;
                    i_precision_digits <= offered_req.prec_digits;
                    i_has_precision <= offered_req.has_prec;
                    i_left_align <= offered_req.left_align;
                    i_zero_pad <= offered_req.zero_pad;
                    i_force_plus <= offered_req.force_plus;
                    i_space_sign <= offered_req.space_sign;
                    i_valid <= 1'b1;
                end else begin
                    i_valid <= 1'b0;
                end
            end
        end
    end

    always @(posedge i_clk) begin
        if (!i_rst_n) begin
            i_ready <= 1'b0;
        end else begin
            i_ready <= !rx_hold && ($urandom_range(99) >= recv_stall_pct);
        end
    end

    // Long receiver hold-off so the formatter backs up and drops o_ready.
    initial begin
        wait (start_backpressure);
        @(posedge i_clk);
        rx_hold <= 1'b1;
        repeat (400) @(posedge i_clk);
        rx_hold <= 1'b0;
    end

    always @(posedge i_clk) begin
        if (i_rst_n && o_valid && i_ready) begin
            if (expected_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected character 0x%02h", o_character));
            end else begin
                want_char = expected_chars.pop_front();
                if (o_character !== want_char.ch) begin
                    report_mismatch($sformatf("character 0x%02h, expected 0x%02h",
                                              o_character, want_char.ch));
                end
                if (o_last_char !== want_char.last) begin
                    report_mismatch($sformatf("last flag %b, expected %b",
                                              o_last_char, want_char.last));
                end
            end
        end
    end

    task automatic queue_req(input t_fmt_req r);
        pending_reqs.push_back(r);
        reqs_queued++;
    endtask

    task automatic wait_drained();
        while (reqs_accepted != reqs_queued || expected_chars.size() != 0) begin
            @(posedge i_clk);
        end
    endtask

    task automatic run_phase(input int idle_pct, input int stall_pct, input int count);
        send_idle_pct <= idle_pct;
        recv_stall_pct <= stall_pct;
        @(posedge i_clk);
        for (int i = 0; i < count; i++) queue_req(random_req());
        wait_drained();
    endtask

    initial begin
        repeat (3) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed corner cases: signs, extremes, saturation and empty fields.
        queue_req(make_req(32'd0, 0, 0, 0, 0, 0, 0, 0));
        queue_req(make_req(32'd0, 0, 0, 1, 0, 0, 0, 0));
        queue_req(make_req(32'd0, 5, 0, 1, 0, 0, 0, 0));
        queue_req(make_req(32'd0, 0, 0, 1, 0, 0, 1, 0));
        queue_req(make_req(32'd0, 0, 0, 1, 0, 0, 0, 1));
        queue_req(make_req(32'h8000_0000, 0, 0, 0, 0, 0, 0, 0));
        queue_req(make_req(32'h7FFF_FFFF, 0, 0, 0, 0, 0, 1, 0));
        queue_req(make_req(32'hFFFF_FFFF, 64, 0, 0, 0, 1, 0, 0));
        queue_req(make_req(32'd123, 127, 0, 0, 1, 0, 0, 0));
        queue_req(make_req(32'd5, 0, 63, 1, 0, 0, 1, 0));
        queue_req(make_req(-32'sd5, 64, 63, 1, 0, 0, 0, 0));
        queue_req(make_req(32'd42, 10, 0, 0, 1, 1, 0, 0));
        queue_req(make_req(32'd42, 10, 4, 1, 0, 1, 0, 0));
        queue_req(make_req(32'd42, 10, 0, 0, 0, 1, 0, 1));
        queue_req(make_req(32'd42, 0, 0, 0, 0, 0, 1, 1));
        queue_req(make_req(-32'sd42, 0, 0, 0, 0, 0, 1, 1));
        queue_req(make_req(32'd7, 3, 0, 0, 1, 0, 0, 1));
        queue_req(make_req(32'h8000_0000, 127, 63, 1, 1, 1, 1, 1));
        queue_req(make_req(32'hFFFF_FFFF, 127, 63, 0, 0, 0, 0, 0));
        queue_req(make_req(32'd1000000000, 12, 0, 0, 0, 1, 0, 0));
        queue_req(make_req(32'd9, 0, 1, 1, 0, 0, 0, 0));
        queue_req(make_req(32'd0, 0, 1, 1, 0, 0, 0, 0));
        queue_req(make_req(32'd0, 64, 0, 0, 0, 1, 0, 0));
        queue_req(make_req(32'd0, 0, 0, 1, 1, 1, 0, 0));
        wait_drained();

        run_phase(0, 0, 100);
        start_backpressure <= 1'b1;
        run_phase(0, 0, 60);
        run_phase(78, 0, 95);
        run_phase(0, 78, 95);
        run_phase(31, 31, 95);

        // Let any trailing request with an empty field finish inside the block.
        repeat (40) @(posedge i_clk);
        while (expected_chars.size() != 0) begin
            report_mismatch("expected character never arrived");
            void'(expected_chars.pop_front());
        end
        if (mismatch_count == 0) begin
            $display("PASS signed_decimal_field_formatter");
        end else begin
            $display("FAIL signed_decimal_field_formatter");
        end
        $finish;
    end

    initial begin
        #3000000;
        $display("FAIL signed_decimal_field_formatter");
        $finish;
    end

endmodule
